// ===== hw/rtl/hevm_pkg.sv =====
// Shared types, widths and constants of the heading error velocity mapper.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package hevm_pkg;

  // Field widths.
  localparam int unsigned VelW   = 16;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned RateW  = 16;

  // Internal datapath widths.
  localparam int unsigned SqW  = 2 * QuatW;         // one quaternion product
  localparam int unsigned HdW  = SqW + 2;           // heading component, Q6.28
  localparam int unsigned PrdW = HdW + VelW;        // heading times velocity
  localparam int unsigned CrW  = PrdW + 1;          // cross and dot products
  localparam int unsigned CwW  = CrW + 2;           // CORDIC x and y with gain
  localparam int unsigned AngW = 16;                // CORDIC angle, Q3.13
  localparam int unsigned ErrW = 15;                // clamped error in [0, pi]
  localparam int unsigned DiffW = 14;               // quarter turn minus error
  localparam int unsigned ProdW = SpeedW + DiffW;   // speed times remaining angle

  // CORDIC.
  localparam int unsigned CordicStages = 14;
  localparam int unsigned AtanEntries  = 24;

  // Angles in Q3.13.
  localparam int unsigned HalfPiQ13 = 12868;
  localparam int unsigned PiQ13     = 25736;

  // Division by a quarter turn as a multiplication by a rounded-up reciprocal.
  // With a 43 bit shift the result is exact for every product below 2^29.
  localparam int unsigned RecipShift = 43;
  localparam int unsigned RecipW     = 30;
  localparam logic [RecipW-1:0] RecipMul =
      RecipW'(((64'd1 << RecipShift) + 64'(HalfPiQ13) - 64'd1) / 64'(HalfPiQ13));
  localparam int unsigned ScaledW = ProdW + RecipW;

  // Reset values of the registers.
  localparam logic [SpeedW-1:0] MaxLinSpeedReset = SpeedW'(1024);
  localparam logic [SpeedW-1:0] MaxAngRateReset  = SpeedW'(8192);

  typedef enum logic [0:0] {
    CfgMaxLinSpeed = 1'b0,
    CfgMaxAngRate  = 1'b1
  } cfg_idx_e;

  typedef logic signed [VelW-1:0]  vel_t;
  typedef logic signed [QuatW-1:0] quat_t;
  typedef logic signed [CwW-1:0]   cw_t;
  typedef logic signed [AngW-1:0]  ang_t;

  typedef struct packed {
    vel_t  vel_x;
    vel_t  vel_y;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    quat_t quat_w;
  } cmd_t;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    ang_t z;
    logic neg;
  } cordic_item_t;

  typedef struct packed {
    ang_t z;
    logic neg;
  } angle_item_t;

  // Arctangent of 2^-idx in Q3.13, rounded to nearest.
  function automatic ang_t atan_q13(input int unsigned idx);
    ang_t val;
    case (idx)
      0:       val = AngW'(6434);
      1:       val = AngW'(3798);
      2:       val = AngW'(2007);
      3:       val = AngW'(1019);
      4:       val = AngW'(511);
      5:       val = AngW'(256);
      6:       val = AngW'(128);
      7:       val = AngW'(64);
      8:       val = AngW'(32);
      9:       val = AngW'(16);
      10:      val = AngW'(8);
      11:      val = AngW'(4);
      12:      val = AngW'(2);
      13:      val = AngW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hevm_front.sv =====
// Front end: heading vector from the quaternion, cross and dot products with
// the velocity, and the quadrant fold that prepares the CORDIC. Uses hevm_pkg.
`default_nettype none

module hevm_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire hevm_pkg::cmd_t        in_cmd_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output hevm_pkg::cordic_item_t     out_item_o
);

  localparam int unsigned NumStages = 5;
  localparam logic signed [hevm_pkg::HdW-1:0] OneQ28 = hevm_pkg::HdW'(1) << 28;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // A stage loads when it is empty or its content moves on.
  assign en[0] = ~v_q[0] | en[1];
  assign en[1] = ~v_q[1] | en[2];
  assign en[2] = ~v_q[2] | en[3];
  assign en[3] = ~v_q[3] | en[4];
  assign en[4] = ~v_q[4] | out_ready_i;

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[4];

  // Stage 0: quaternion products.
  hevm_pkg::vel_t                   vx0_q, vy0_q;
  logic signed [hevm_pkg::SqW-1:0] sq_y_q, sq_z_q, xy_q, wz_q;
  // Stage 1: heading vector.
  hevm_pkg::vel_t                   vx1_q, vy1_q;
  logic signed [hevm_pkg::HdW-1:0] hx_q, hy_q;
  // Stage 2: the four heading-velocity products.
  logic signed [hevm_pkg::PrdW-1:0] hxvy_q, hyvx_q, hxvx_q, hyvy_q;
  // Stage 3: cross and dot.
  logic signed [hevm_pkg::CrW-1:0] cross_q, dot_q;
  // Stage 4: CORDIC start vector.
  hevm_pkg::cordic_item_t           item_q;

  logic signed [hevm_pkg::SqW:0]    sum_sq, sum_xw;
  logic signed [hevm_pkg::HdW-1:0] hx_d, hy_d;
  logic signed [hevm_pkg::PrdW-1:0] hxvy_d, hyvx_d, hxvx_d, hyvy_d;
  logic signed [hevm_pkg::CrW-1:0] cross_d, dot_d;
  hevm_pkg::cw_t                    abs_cross, neg_dot;
  hevm_pkg::cordic_item_t           item_d;

  always_comb begin
    sum_sq = (hevm_pkg::SqW+1)'(sq_y_q) + (hevm_pkg::SqW+1)'(sq_z_q);
    sum_xw = (hevm_pkg::SqW+1)'(xy_q) + (hevm_pkg::SqW+1)'(wz_q);
    hx_d   = OneQ28 - {sum_sq, 1'b0};
    hy_d   = {sum_xw, 1'b0};
  end

  always_comb begin
    hxvy_d = hx_q * vy1_q;
    hyvx_d = hy_q * vx1_q;
    hxvx_d = hx_q * vx1_q;
    hyvy_d = hy_q * vy1_q;
  end

  always_comb begin
    cross_d = hevm_pkg::CrW'(hxvy_q) - hevm_pkg::CrW'(hyvx_q);
    dot_d   = hevm_pkg::CrW'(hxvx_q) + hevm_pkg::CrW'(hyvy_q);
  end

  // Fold the error into the right half plane: a negative dot product is
  // rotated by a quarter turn and the start angle carries it.
  always_comb begin
    abs_cross = cross_q[hevm_pkg::CrW-1] ? -hevm_pkg::CwW'(cross_q)
                                         : hevm_pkg::CwW'(cross_q);
    neg_dot   = -hevm_pkg::CwW'(dot_q);
    item_d.neg = cross_q[hevm_pkg::CrW-1];
    if (dot_q[hevm_pkg::CrW-1]) begin
      item_d.x = abs_cross;
      item_d.y = neg_dot;
      item_d.z = hevm_pkg::AngW'(hevm_pkg::HalfPiQ13);
    end else begin
      item_d.x = hevm_pkg::CwW'(dot_q);
      item_d.y = abs_cross;
      item_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vx0_q  <= in_cmd_i.vel_x;
      vy0_q  <= in_cmd_i.vel_y;
      sq_y_q <= in_cmd_i.quat_y * in_cmd_i.quat_y;
      sq_z_q <= in_cmd_i.quat_z * in_cmd_i.quat_z;
      xy_q   <= in_cmd_i.quat_x * in_cmd_i.quat_y;
      wz_q   <= in_cmd_i.quat_w * in_cmd_i.quat_z;
    end
    if (en[1]) begin
      vx1_q <= vx0_q;
      vy1_q <= vy0_q;
      hx_q  <= hx_d;
      hy_q  <= hy_d;
    end
    if (en[2]) begin
      hxvy_q <= hxvy_d;
      hyvx_q <= hyvx_d;
      hxvx_q <= hxvx_d;
      hyvy_q <= hyvy_d;
    end
    if (en[3]) begin
      cross_q <= cross_d;
      dot_q   <= dot_d;
    end
    if (en[4]) begin
      item_q <= item_d;
    end
  end

  assign out_item_o = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hevm_cordic.sv =====
// Unrolled vectoring CORDIC, one iteration per register stage, that turns
// the folded cross/dot vector into an angle in Q3.13. Uses hevm_pkg.
`default_nettype none

module hevm_cordic (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire hevm_pkg::cordic_item_t in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output hevm_pkg::angle_item_t       out_item_o
);

  localparam int unsigned NumStages = hevm_pkg::CordicStages;

  logic [NumStages-1:0]   v_q;
  logic [NumStages-1:0]   en;
  hevm_pkg::cordic_item_t st_q [NumStages];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    localparam hevm_pkg::ang_t AtanK = hevm_pkg::atan_q13(k);

    logic                   prev_v;
    hevm_pkg::cordic_item_t prev;
    hevm_pkg::cordic_item_t nxt;
    hevm_pkg::cw_t          xs, ys;

    if (k == 0) begin : g_first
      assign prev_v = in_valid_i;
      assign prev   = in_item_i;
    end else begin : g_next
      assign prev_v = v_q[k-1];
      assign prev   = st_q[k-1];
    end

    if (k == NumStages - 1) begin : g_last
      assign en[k] = ~v_q[k] | out_ready_i;
    end else begin : g_inner
      assign en[k] = ~v_q[k] | en[k+1];
    end

    // Rotate toward the x axis: the sign of y picks the direction.
    always_comb begin
      xs  = prev.x >>> k;
      ys  = prev.y >>> k;
      nxt = prev;
      if (k < hevm_pkg::AtanEntries) begin
        if (!prev.y[hevm_pkg::CwW-1]) begin
          nxt.x = prev.x + ys;
          nxt.y = prev.y - xs;
          nxt.z = prev.z + AtanK;
        end else begin
          nxt.x = prev.x - ys;
          nxt.y = prev.y + xs;
          nxt.z = prev.z - AtanK;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign in_ready_o     = en[0];
  assign out_valid_o    = v_q[NumStages-1];
  assign out_item_o.z   = st_q[NumStages-1].z;
  assign out_item_o.neg = st_q[NumStages-1].neg;

endmodule

`default_nettype wire

// ===== hw/rtl/hevm_back.sv =====
// Back end: clamps the heading error, forms the turn rate and scales the
// forward speed, ending in the output register. Uses hevm_pkg.
`default_nettype none

module hevm_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire hevm_pkg::angle_item_t       in_item_i,
  input  wire logic [hevm_pkg::SpeedW-1:0] max_lin_speed_i,
  input  wire logic [hevm_pkg::SpeedW-1:0] max_ang_rate_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [hevm_pkg::SpeedW-1:0]      linear_speed_o,
  output logic signed [hevm_pkg::RateW-1:0] angular_rate_o
);

  localparam int unsigned NumStages = 4;
  localparam int unsigned LinLsb = hevm_pkg::RecipShift;
  localparam int unsigned LinMsb = hevm_pkg::RecipShift + hevm_pkg::SpeedW - 1;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  assign en[0] = ~v_q[0] | en[1];
  assign en[1] = ~v_q[1] | en[2];
  assign en[2] = ~v_q[2] | en[3];
  assign en[3] = ~v_q[3] | out_ready_i;

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[3];

  // Stage 0: error clamped to [0, pi].
  logic [hevm_pkg::ErrW-1:0]            err_q, err_d;
  logic                                 neg_q;
  // Stage 1: remaining angle to a quarter turn and signed turn rate.
  logic [hevm_pkg::DiffW-1:0]           diff_q, diff_d;
  logic signed [hevm_pkg::RateW-1:0]    ang1_q, ang1_d;
  // Stage 2: speed times remaining angle.
  logic [hevm_pkg::ProdW-1:0]           prod_q, prod_d;
  logic signed [hevm_pkg::RateW-1:0]    ang2_q;
  // Stage 3: output register.
  logic [hevm_pkg::SpeedW-1:0]          lin_q, lin_d;
  logic signed [hevm_pkg::RateW-1:0]    ang3_q;

  logic [hevm_pkg::ErrW-1:0]            mag;
  logic [hevm_pkg::ScaledW-1:0]         scaled;

  always_comb begin
    if (in_item_i.z[hevm_pkg::AngW-1]) begin
      err_d = '0;
    end else if (in_item_i.z > hevm_pkg::AngW'(hevm_pkg::PiQ13)) begin
      err_d = hevm_pkg::ErrW'(hevm_pkg::PiQ13);
    end else begin
      err_d = in_item_i.z[hevm_pkg::ErrW-1:0];
    end
  end

  always_comb begin
    if (err_q > hevm_pkg::ErrW'(hevm_pkg::HalfPiQ13)) begin
      diff_d = '0;
    end else begin
      diff_d = hevm_pkg::DiffW'(hevm_pkg::ErrW'(hevm_pkg::HalfPiQ13) - err_q);
    end
    mag    = (err_q < max_ang_rate_i) ? err_q : max_ang_rate_i;
    ang1_d = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Division by a quarter turn: the product times the reciprocal, shifted.
  always_comb begin
    prod_d = max_lin_speed_i * diff_q;
    scaled = prod_q * hevm_pkg::RecipMul;
    lin_d  = scaled[LinMsb:LinLsb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      err_q <= err_d;
      neg_q <= in_item_i.neg;
    end
    if (en[1]) begin
      diff_q <= diff_d;
      ang1_q <= ang1_d;
    end
    if (en[2]) begin
      prod_q <= prod_d;
      ang2_q <= ang1_q;
    end
    if (en[3]) begin
      lin_q  <= lin_d;
      ang3_q <= ang2_q;
    end
  end

  assign linear_speed_o = lin_q;
  assign angular_rate_o = ang3_q;

endmodule

`default_nettype wire

// ===== hw/rtl/heading_error_velocity_mapper.sv =====
// Top level of the heading error velocity mapper: configuration registers,
// stream ports and the front, CORDIC and back pipelines. Uses hevm_pkg.
`default_nettype none

// The block turns a desired planar velocity and the robot orientation
// quaternion into a differential-drive command. It builds the heading vector
// from the quaternion, takes the cross and dot products with the velocity and
// finds the unsigned heading error with a 14-iteration vectoring CORDIC. The
// forward speed falls linearly from max_linear_speed at zero error to zero at
// a quarter turn and stays zero beyond it; the turn rate is the error clamped
// to max_angular_rate and takes the sign of the cross product, where a zero
// cross product counts as positive. An item whose velocity is zero in both
// components is accepted and produces no result. The pipeline takes one item
// per clock while the output is not stalled; an accepted item passes through
// five front-end stages, one stage per CORDIC iteration and four back-end
// stages on its way to the output. Every stage has its own valid bit and
// loads whenever it is empty or moving on, so a stalled output fills the
// pipeline before the input stops, and nothing is dropped or repeated. The
// configuration registers are always ready; write them only while no item is
// in flight.

module heading_error_velocity_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // From bit 0: vel_x, vel_y, quat_x, quat_y, quat_z, quat_w (16 bits each).
  input  wire logic [95:0] s_axis_tdata,

  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // From bit 0: linear_speed (15 bits), angular_rate (16 bits), one zero bit.
  output logic [31:0]      m_axis_tdata,

  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);

  logic [hevm_pkg::SpeedW-1:0] max_lin_speed_q;
  logic [hevm_pkg::SpeedW-1:0] max_ang_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_speed_q <= hevm_pkg::MaxLinSpeedReset;
      max_ang_rate_q  <= hevm_pkg::MaxAngRateReset;
    end else if (cfg_valid_i) begin
      case (hevm_pkg::cfg_idx_e'(cfg_index_i))
        hevm_pkg::CfgMaxLinSpeed: max_lin_speed_q <= cfg_data_i;
        hevm_pkg::CfgMaxAngRate:  max_ang_rate_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input item. A zero velocity has no direction, so such an
  // item is taken from the port but never enters the pipeline.
  hevm_pkg::cmd_t cmd;
  logic           cmd_valid;

  always_comb begin
    cmd.vel_x  = s_axis_tdata[15:0];
    cmd.vel_y  = s_axis_tdata[31:16];
    cmd.quat_x = s_axis_tdata[47:32];
    cmd.quat_y = s_axis_tdata[63:48];
    cmd.quat_z = s_axis_tdata[79:64];
    cmd.quat_w = s_axis_tdata[95:80];
    cmd_valid  = s_axis_tvalid & ((cmd.vel_x != '0) | (cmd.vel_y != '0));
  end

  logic                   front_valid, front_ready;
  hevm_pkg::cordic_item_t front_item;
  logic                   angle_valid, angle_ready;
  hevm_pkg::angle_item_t  angle_item;

  logic [hevm_pkg::SpeedW-1:0]        linear_speed;
  logic signed [hevm_pkg::RateW-1:0]  angular_rate;

  hevm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  hevm_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (angle_valid),
    .out_ready_i (angle_ready),
    .out_item_o  (angle_item)
  );

  hevm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (angle_valid),
    .in_ready_o      (angle_ready),
    .in_item_i       (angle_item),
    .max_lin_speed_i (max_lin_speed_q),
    .max_ang_rate_i  (max_ang_rate_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .linear_speed_o  (linear_speed),
    .angular_rate_o  (angular_rate)
  );

  assign m_axis_tdata = {1'b0, angular_rate, linear_speed};

endmodule

`default_nettype wire

// ===== bench/heading_error_velocity_mapper_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heading_error_velocity_mapper: stream driver,
// result monitor and a bit-exact predictor of the heading error, speed and turn rate.
// Depends on hevm_pkg and the block's top level only.

module heading_error_velocity_mapper_tb;

  // Cycles the receiver refuses results while the sender keeps pushing.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // Pipeline depth plus margin; used before register writes and at the end.
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 7;
  localparam int CMDS_PER_PHASE = 148;

  localparam longint QUARTER_TURN = longint'(hevm_pkg::HalfPiQ13);
  localparam longint HALF_TURN = longint'(hevm_pkg::PiQ13);
  localparam longint ATAN_Q13 [14] = '{6434, 3798, 2007, 1019, 511, 256, 128,
                                       64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic [hevm_pkg::SpeedW-1:0]       speed;
    logic signed [hevm_pkg::RateW-1:0] rate;
  } drive_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // From bit 0: vel_x, vel_y, quat_x, quat_y, quat_z, quat_w (16 bits each).
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // From bit 0: linear_speed (15 bits), angular_rate (16 bits), one zero bit.
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = hevm_pkg::CfgMaxLinSpeed;
  logic [14:0] cfg_data_i = '0;

  // Local copy of the block's registers, and a flag set by the predictor.
  logic [hevm_pkg::SpeedW-1:0] lim_speed = hevm_pkg::MaxLinSpeedReset;
  logic [hevm_pkg::SpeedW-1:0] lim_rate = hevm_pkg::MaxAngRateReset;
  bit                          moving = 1'b0;

  hevm_pkg::cmd_t pending_cmds[$];
  drive_cmd_t     expected_drive_q[$];

  int cmds_queued = 0;
  int cmds_offered = 0;
  int cmds_accepted = 0;
  int results_taken = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  // Pacing knobs set per phase by the stimulus process.
  int send_idle_max = 3;
  int recv_idle_max = 3;
  int hold_req = 0;

  always #1 clk_i = ~clk_i;

  heading_error_velocity_mapper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Vectoring CORDIC on y >= 0. A vector in the left half plane is first
  // turned a quarter turn clockwise so the iterations converge; the angle is
  // then clamped to [0, pi]. Signed >>> rounds toward minus infinity.
  function automatic longint heading_error_q13(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = QUARTER_TURN;
    end
    for (int i = 0; i < hevm_pkg::CordicStages && i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_Q13[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_Q13[i];
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_TURN) z = HALF_TURN;
    return z;
  endfunction

  // Works out the drive command for one item. Returns 0 when the velocity is
  // zero, in which case the block emits nothing.
  function automatic bit predict_drive_cmd(input hevm_pkg::cmd_t c, output drive_cmd_t r);
    longint vx, vy, qx, qy, qz, qw;
    longint hx, hy, crs, dt, err, lin, mag;
    vx = c.vel_x;
    vy = c.vel_y;
    qx = c.quat_x;
    qy = c.quat_y;
    qz = c.quat_z;
    qw = c.quat_w;
    r.speed = '0;
    r.rate = '0;
    if (vx == 0 && vy == 0) return 1'b0;
    moving = 1'b1;
    // Heading components in Q6.28, exact; no normalization is needed since
    // only the angle between the two vectors matters.
    hx = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
    hy = 2 * (qx * qy + qw * qz);
    crs = hx * vy - hy * vx;
    dt = hx * vx + hy * vy;
    err = heading_error_q13(crs < 0 ? -crs : crs, dt);
    if (err > QUARTER_TURN) lin = 0;
    else lin = (longint'(lim_speed) * (QUARTER_TURN - err)) / QUARTER_TURN;
    mag = err < longint'(lim_rate) ? err : longint'(lim_rate);
    // A zero cross product turns the positive way.
    if (crs < 0) mag = -mag;
    r.speed = hevm_pkg::SpeedW'(lin);
    r.rate = hevm_pkg::RateW'(mag);
    return 1'b1;
  endfunction

  function automatic hevm_pkg::cmd_t make_cmd(int vx, int vy, int qx, int qy, int qz, int qw);
    hevm_pkg::cmd_t c;
    c.vel_x = hevm_pkg::VelW'(vx);
    c.vel_y = hevm_pkg::VelW'(vy);
    c.quat_x = hevm_pkg::QuatW'(qx);
    c.quat_y = hevm_pkg::QuatW'(qy);
    c.quat_z = hevm_pkg::QuatW'(qz);
    c.quat_w = hevm_pkg::QuatW'(qw);
    return c;
  endfunction

  // Most items carry a unit yaw quaternion with a little tilt noise, which is
  // what a planar robot reports; the rest use raw quaternion bits. Velocity
  // magnitudes are spread over all scales, with some zero components.
  function automatic hevm_pkg::cmd_t random_cmd();
    hevm_pkg::cmd_t c;
    int   pick;
    real  half_yaw;
    int   qw;
    int   qz;
    pick = $urandom_range(0, 99);
    c.vel_x = hevm_pkg::VelW'($urandom);
    c.vel_y = hevm_pkg::VelW'($urandom);
    c.vel_x = c.vel_x >>> $urandom_range(0, 15);
    c.vel_y = c.vel_y >>> $urandom_range(0, 15);
    if (pick < 5) begin
      c.vel_x = '0;
      c.vel_y = '0;
    end else if (pick < 9) begin
      c.vel_x = '0;
    end else if (pick < 13) begin
      c.vel_y = '0;
    end
    if (pick < 75) begin
      half_yaw = $urandom_range(0, 31416) / 10000.0;
      qw = $rtoi($cos(half_yaw) * 16384.0);
      qz = $rtoi($sin(half_yaw) * 16384.0);
      if ($urandom_range(0, 1) == 1) begin
        qw = -qw;
        qz = -qz;
      end
      c.quat_w = hevm_pkg::QuatW'(qw);
      c.quat_z = hevm_pkg::QuatW'(qz);
      c.quat_x = hevm_pkg::QuatW'(int'($urandom_range(0, 40)) - 20);
      c.quat_y = hevm_pkg::QuatW'(int'($urandom_range(0, 40)) - 20);
    end else begin
      c.quat_x = hevm_pkg::QuatW'($urandom);
      c.quat_y = hevm_pkg::QuatW'($urandom);
      c.quat_z = hevm_pkg::QuatW'($urandom);
      c.quat_w = hevm_pkg::QuatW'($urandom);
    end
    return c;
  endfunction

  task automatic queue_cmd(input hevm_pkg::cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
    cmds_queued++;
  endtask

  // One register write through the configuration channel, mirrored in the
  // local copy once the handshake completes.
  task automatic write_limit(input hevm_pkg::cfg_idx_e idx, input logic [14:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hevm_pkg::CfgMaxLinSpeed: lim_speed = val;
      hevm_pkg::CfgMaxAngRate:  lim_rate = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued item was taken and every result arrived, then
  // lets the pipeline run dry.
  task automatic drain_pipeline();
    wait (cmds_accepted == cmds_queued);
    wait (expected_drive_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Input acceptance: every item the block takes is run through the predictor
  // right here, so the prediction always uses the registers in force.
  hevm_pkg::cmd_t taken_cmd;
  drive_cmd_t     taken_exp;
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cmds_accepted++;
      taken_cmd = make_cmd($signed(s_axis_tdata[15:0]), $signed(s_axis_tdata[31:16]),
                           $signed(s_axis_tdata[47:32]), $signed(s_axis_tdata[63:48]),
                           $signed(s_axis_tdata[79:64]), $signed(s_axis_tdata[95:80]));
      if (predict_drive_cmd(taken_cmd, taken_exp))
        expected_drive_q.insert(expected_drive_q.size(), taken_exp);
    end
  end

  // Sender. After each accepted item it draws a gap, then puts the next
  // pending item on the bus and holds it until the block takes it.
  int acc_seen = 0;
  int send_wait = 0;
  hevm_pkg::cmd_t next_cmd;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (acc_seen != cmds_accepted) begin
        acc_seen = cmds_accepted;
        send_wait = $urandom_range(0, send_idle_max);
      end
      if (cmds_offered == cmds_accepted) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          s_axis_tdata <= {next_cmd.quat_w, next_cmd.quat_z, next_cmd.quat_y,
                           next_cmd.quat_x, next_cmd.vel_y, next_cmd.vel_x};
          s_axis_tvalid <= 1'b1;
          cmds_offered++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. It stalls a random number of cycles after each result, and on
  // request refuses results for a long stretch so the pipeline backs up
  // into the input port.
  int hold_served = 0;
  int hold_left = 0;
  int res_seen = 0;
  int recv_wait = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (res_seen != results_taken) begin
        res_seen = results_taken;
        recv_wait = $urandom_range(0, recv_idle_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: each result against the oldest prediction.
  drive_cmd_t want;
  logic [hevm_pkg::SpeedW-1:0]       got_speed;
  logic signed [hevm_pkg::RateW-1:0] got_rate;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_taken++;
      got_speed = m_axis_tdata[14:0];
      got_rate = m_axis_tdata[30:15];
      if (expected_drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: speed %0d rate %0d",
                   $realtime, got_speed, got_rate);
      end else begin
        want = expected_drive_q.pop_front();
        if (got_speed !== want.speed || got_rate !== want.rate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d: speed exp %0d got %0d, rate exp %0d got %0d",
                     $realtime, results_taken, want.speed, got_speed, want.rate,
                     got_rate);
        end
      end
    end
  end

  // Hang detector: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases under the reset limits, then phases of
  // random items, each under its own pair of limits and its own pacing.
  logic [14:0] phase_speed [NUM_PHASES] = '{15'd32767, 15'd0, 15'd32767, 15'd1,
                                            15'd12345, 15'd32767, 15'd512};
  logic [14:0] phase_rate [NUM_PHASES] = '{15'd25736, 15'd0, 15'd32767, 15'd1,
                                           15'd4000, 15'd12868, 15'd25736};
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity orientation looks along +x.
    queue_cmd(make_cmd(0, 0, 0, 0, 0, 16384));          // zero velocity, no result
    queue_cmd(make_cmd(1024, 0, 0, 0, 0, 16384));       // straight ahead, zero cross
    queue_cmd(make_cmd(-1024, 0, 0, 0, 0, 16384));      // straight behind, zero cross
    queue_cmd(make_cmd(0, 1024, 0, 0, 0, 16384));       // exactly a quarter turn left
    queue_cmd(make_cmd(0, -1024, 0, 0, 0, 16384));      // quarter turn right
    queue_cmd(make_cmd(1024, 1, 0, 0, 0, 16384));       // tiny positive cross
    queue_cmd(make_cmd(1024, -1, 0, 0, 0, 16384));      // tiny negative cross
    queue_cmd(make_cmd(32767, 32767, 0, 0, 0, 16384));
    queue_cmd(make_cmd(-32768, -32768, 0, 0, 0, 16384));
    queue_cmd(make_cmd(-32768, 32767, 0, 0, 11585, 11585));
    queue_cmd(make_cmd(700, -700, 0, 0, -16384, 0));
    // Heading vector collapses to zero.
    queue_cmd(make_cmd(100, 200, 0, 8192, 8192, 0));
    // Quaternions far from unit length, several at the field extremes.
    queue_cmd(make_cmd(1, 1, 32767, 32767, 32767, 32767));
    queue_cmd(make_cmd(-1, 0, -32768, -32768, -32768, -32768));
    queue_cmd(make_cmd(0, 1, 16384, 16384, 16384, 16384));
    queue_cmd(make_cmd(5, -7, -16384, -16384, -16384, -16384));
    queue_cmd(make_cmd(1, 0, -32768, 32767, -32768, 32767));
    queue_cmd(make_cmd(0, 0, -32768, -32768, -32768, -32768));
    drain_pipeline();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(hevm_pkg::CfgMaxLinSpeed, phase_speed[ph]);
      write_limit(hevm_pkg::CfgMaxAngRate, phase_rate[ph]);
      send_idle_max = (ph % 3 == 1) ? 0 : 3;
      recv_idle_max = (ph % 3 == 2) ? 0 : 3;
      if (ph == 2) begin
        // Back-to-back input against a stalled output.
        send_idle_max = 0;
        hold_req++;
      end
      for (int k = 0; k < CMDS_PER_PHASE; k++) queue_cmd(random_cmd());
      drain_pipeline();
    end

    if (mismatches == 0 && expected_drive_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
